// ===== rtl/rtdw_pkg.sv =====
package rtdw_pkg;

  localparam int SQRT_STEPS = 25;
  localparam logic [14:0] MIN_SPEED = 15'd410;
  localparam logic [31:0] PI_Q29 = 32'd1686629713;

  localparam logic [2:0] REG_GAIN_LINEAR = 3'd0;
  localparam logic [2:0] REG_GAIN_ANGULAR = 3'd1;
  localparam logic [2:0] REG_SPEED_LIMIT = 3'd2;
  localparam logic [2:0] REG_TURN_LIMIT = 3'd3;
  localparam logic [2:0] REG_HEADING_TOL = 3'd4;
  localparam logic [2:0] REG_DISTANCE_TOL = 3'd5;

  typedef enum logic [1:0] {
    PH_ROTATE = 2'd0,
    PH_DRIVE = 2'd1,
    PH_REACHED = 2'd2,
    PH_CANCELED = 2'd3
  } phase_t;

  typedef struct packed {
    logic [15:0] gain_linear;
    logic [15:0] gain_angular;
    logic [14:0] speed_limit;
    logic [14:0] turn_limit;
    logic [13:0] heading_tolerance;
    logic [15:0] distance_tolerance;
  } cfg_t;

  typedef struct packed {
    logic        cancel;
    logic        zero;
    logic        far;
    logic [15:0] heading;
    logic [42:0] x;
    logic [42:0] y;
    logic [31:0] z;
    logic [49:0] nsh;
    logic [27:0] rem;
    logic [24:0] root;
  } it_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0: a = 32'd536870912;
      5'd1: a = 32'd316933406;
      5'd2: a = 32'd167458907;
      5'd3: a = 32'd85004756;
      5'd4: a = 32'd42667331;
      5'd5: a = 32'd21354465;
      5'd6: a = 32'd10679838;
      5'd7: a = 32'd5340245;
      5'd8: a = 32'd2670163;
      5'd9: a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/rtdw_front.sv =====
module rtdw_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [23:0]        goal_x,
  input  logic [23:0]        goal_y,
  input  logic [23:0]        pos_x,
  input  logic [23:0]        pos_y,
  input  logic [15:0]        heading,
  input  logic               cancel,
  input  rtdw_pkg::cfg_t     cfg,
  output logic               out_valid,
  output rtdw_pkg::it_t      out_st
);

  logic               v1_r, v2_r, v3_r;
  logic signed [24:0] dx_r, dy_r;
  logic [15:0]        hd1_r, hd2_r;
  logic               cn1_r, cn2_r;
  logic signed [49:0] dxx_r, dyy_r;
  logic [31:0]        tol2_r;
  logic [42:0]        xi_r, yi_r;
  logic [31:0]        zi_r;
  logic               zero_r;
  rtdw_pkg::it_t      st_r;

  logic signed [24:0] dx_nxt, dy_nxt;
  logic signed [42:0] xs, ys;
  logic [49:0]        d2;

  assign dx_nxt = $signed({goal_x[23], goal_x}) - $signed({pos_x[23], pos_x});
  assign dy_nxt = $signed({goal_y[23], goal_y}) - $signed({pos_y[23], pos_y});
  assign xs = {{2{dx_r[24]}}, dx_r, 16'b0};
  assign ys = {{2{dy_r[24]}}, dy_r, 16'b0};
  assign d2 = dxx_r + dyy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      hd1_r <= heading;
      cn1_r <= cancel;

      dxx_r <= dx_r * dx_r;
      dyy_r <= dy_r * dy_r;
      tol2_r <= cfg.distance_tolerance * cfg.distance_tolerance;
      hd2_r <= hd1_r;
      cn2_r <= cn1_r;
      zero_r <= (dx_r == 25'sd0) && (dy_r == 25'sd0);
      if (dx_r[24]) begin
        xi_r <= -xs;
        yi_r <= -ys;
        zi_r <= 32'h8000_0000;
      end else begin
        xi_r <= xs;
        yi_r <= ys;
        zi_r <= 32'h0;
      end

      st_r.cancel <= cn2_r;
      st_r.zero <= zero_r;
      st_r.far <= d2 > {18'b0, tol2_r};
      st_r.heading <= hd2_r;
      st_r.x <= xi_r;
      st_r.y <= yi_r;
      st_r.z <= zi_r;
      st_r.nsh <= d2;
      st_r.rem <= '0;
      st_r.root <= '0;
    end
  end

  assign out_valid = v3_r;
  assign out_st = st_r;

endmodule

// ===== rtl/rtdw_iter.sv =====
module rtdw_iter #(
  parameter int STEP = 0,
  parameter bit ROT = 1'b1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  rtdw_pkg::it_t in_st,
  output logic          out_valid,
  output rtdw_pkg::it_t out_st
);

  logic          v_r;
  rtdw_pkg::it_t st_r;
  rtdw_pkg::it_t st_nxt;

  logic [27:0]        rem_w, trial;
  logic signed [42:0] x, y, xsh, ysh;
  logic [31:0]        a;

  assign rem_w = {in_st.rem[25:0], in_st.nsh[49:48]};
  assign trial = {1'b0, in_st.root, 2'b01};
  assign x = $signed(in_st.x);
  assign y = $signed(in_st.y);
  assign xsh = x >>> STEP;
  assign ysh = y >>> STEP;
  assign a = rtdw_pkg::atan_entry(5'(STEP));

  always_comb begin
    st_nxt = in_st;
    st_nxt.nsh = {in_st.nsh[47:0], 2'b00};
    if (rem_w >= trial) begin
      st_nxt.rem = rem_w - trial;
      st_nxt.root = {in_st.root[23:0], 1'b1};
    end else begin
      st_nxt.rem = rem_w;
      st_nxt.root = {in_st.root[23:0], 1'b0};
    end
    if (ROT) begin
      if (!y[42]) begin
        st_nxt.x = x + ysh;
        st_nxt.y = y - xsh;
        st_nxt.z = in_st.z + a;
      end else begin
        st_nxt.x = x - ysh;
        st_nxt.y = y + xsh;
        st_nxt.z = in_st.z - a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_st = st_r;

endmodule

// ===== rtl/rtdw_back.sv =====
module rtdw_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  rtdw_pkg::it_t  in_st,
  input  rtdw_pkg::cfg_t cfg,
  output logic           out_valid,
  output logic [14:0]    forward_speed,
  output logic [15:0]    turn_rate,
  output logic [1:0]     phase
);

  logic        v1_r, v2_r, v3_r, v4_r;
  logic        cn1_r, cn2_r, cn3_r;
  logic        rot1_r, rot2_r, rot3_r;
  logic        far1_r, far2_r, far3_r;
  logic        neg1_r, neg2_r, neg3_r;
  logic [24:0] dist_r;
  logic [15:0] mag_r;
  logic [31:0] p1_r;
  logic [40:0] sp_r;
  logic [63:0] p2_r;
  logic [14:0] spd_r;
  logic [14:0] fs_r;
  logic [15:0] tr_r;
  logic [1:0]  ph_r;

  logic [15:0] b, err, mag;
  logic [31:0] zr;
  logic [40:0] sp_sum;
  logic [28:0] s;
  logic [14:0] spd_nxt;
  logic [19:0] q;
  logic [14:0] qc;

  assign zr = in_st.z + 32'h0000_8000;
  assign b = in_st.zero ? 16'h0 : zr[31:16];
  assign err = b - in_st.heading;
  assign mag = err[15] ? (16'h0 - err) : err;

  assign sp_sum = sp_r + 41'd2048;
  assign s = sp_sum[40:12];
  always_comb begin
    if (s > {14'b0, cfg.speed_limit}) begin
      spd_nxt = cfg.speed_limit;
    end else begin
      spd_nxt = s[14:0];
    end
    if (spd_nxt < rtdw_pkg::MIN_SPEED) begin
      spd_nxt = rtdw_pkg::MIN_SPEED;
    end
  end

  assign q = p2_r[63:44] + {19'b0, p2_r[43]};
  assign qc = (q > {5'b0, cfg.turn_limit}) ? cfg.turn_limit : q[14:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cn1_r <= in_st.cancel;
      far1_r <= in_st.far;
      neg1_r <= err[15];
      rot1_r <= mag > {2'b0, cfg.heading_tolerance};
      mag_r <= mag;
      dist_r <= in_st.root + {24'b0, (in_st.rem > {3'b0, in_st.root})};

      cn2_r <= cn1_r;
      far2_r <= far1_r;
      neg2_r <= neg1_r;
      rot2_r <= rot1_r;
      p1_r <= cfg.gain_angular * mag_r;
      sp_r <= cfg.gain_linear * dist_r;

      cn3_r <= cn2_r;
      far3_r <= far2_r;
      neg3_r <= neg2_r;
      rot3_r <= rot2_r;
      p2_r <= p1_r * rtdw_pkg::PI_Q29;
      spd_r <= spd_nxt;

      if (cn3_r) begin
        fs_r <= '0;
        tr_r <= '0;
        ph_r <= rtdw_pkg::PH_CANCELED;
      end else if (rot3_r) begin
        fs_r <= '0;
        tr_r <= neg3_r ? (16'h0 - {1'b0, qc}) : {1'b0, qc};
        ph_r <= rtdw_pkg::PH_ROTATE;
      end else if (far3_r) begin
        fs_r <= spd_r;
        tr_r <= '0;
        ph_r <= rtdw_pkg::PH_DRIVE;
      end else begin
        fs_r <= '0;
        tr_r <= '0;
        ph_r <= rtdw_pkg::PH_REACHED;
      end
    end
  end

  assign out_valid = v4_r;
  assign forward_speed = fs_r;
  assign turn_rate = tr_r;
  assign phase = ph_r;

endmodule

// ===== rtl/rotate_then_drive_waypoint_controller.sv =====
// Go-to-point controller for a differential drive: each request carries goal, position,
// heading and a cancel flag, and yields one command with speed, turn rate and phase.
// A new request is taken every cycle while the output is not stalled; each one passes
// through 3 front stages, 25 square-root stages that also carry the CORDIC_STEPS bearing
// iterations, and 4 output stages. The whole pipeline holds while the output register
// is full and not taken.
module rotate_then_drive_waypoint_controller #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // goal_x[23:0], goal_y[47:24], pos_x[71:48], pos_y[95:72], heading[111:96],
  // cancel[112], zero fill above.
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // forward_speed[14:0], turn_rate[30:15], zero fill above.
  output logic [31:0]  out_tdata,
  // phase[1:0].
  output logic [1:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);

  localparam int NI = rtdw_pkg::SQRT_STEPS;

  rtdw_pkg::cfg_t cfg_r;
  logic           adv;
  logic           iv [0:NI];
  rtdw_pkg::it_t  ist [0:NI];
  logic [14:0]    fs;
  logic [15:0]    tr;
  logic [1:0]     ph;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_linear <= 16'd2048;
      cfg_r.gain_angular <= 16'd8192;
      cfg_r.speed_limit <= 15'd2048;
      cfg_r.turn_limit <= 15'd2662;
      cfg_r.heading_tolerance <= 14'd522;
      cfg_r.distance_tolerance <= 16'd205;
    end else if (cfg_we) begin
      case (cfg_index)
        rtdw_pkg::REG_GAIN_LINEAR: cfg_r.gain_linear <= cfg_wdata;
        rtdw_pkg::REG_GAIN_ANGULAR: cfg_r.gain_angular <= cfg_wdata;
        rtdw_pkg::REG_SPEED_LIMIT: cfg_r.speed_limit <= cfg_wdata[14:0];
        rtdw_pkg::REG_TURN_LIMIT: cfg_r.turn_limit <= cfg_wdata[14:0];
        rtdw_pkg::REG_HEADING_TOL: cfg_r.heading_tolerance <= cfg_wdata[13:0];
        rtdw_pkg::REG_DISTANCE_TOL: cfg_r.distance_tolerance <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;

  rtdw_front u_front (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(in_tvalid),
    .goal_x(in_tdata[23:0]), .goal_y(in_tdata[47:24]),
    .pos_x(in_tdata[71:48]), .pos_y(in_tdata[95:72]),
    .heading(in_tdata[111:96]), .cancel(in_tdata[112]), .cfg(cfg_r),
    .out_valid(iv[0]), .out_st(ist[0])
  );

  for (genvar k = 0; k < NI; k++) begin : g_iter
    rtdw_iter #(.STEP(k), .ROT(k < CORDIC_STEPS)) u_iter (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .in_valid(iv[k]), .in_st(ist[k]),
      .out_valid(iv[k+1]), .out_st(ist[k+1])
    );
  end

  rtdw_back u_back (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(iv[NI]), .in_st(ist[NI]),
    .cfg(cfg_r), .out_valid(out_tvalid),
    .forward_speed(fs), .turn_rate(tr), .phase(ph)
  );

  assign out_tdata = {1'b0, tr, fs};
  assign out_tuser = ph;

  a_cancel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == rtdw_pkg::PH_CANCELED |-> out_tdata == 32'h0)
    else $error("canceled command carries drive");

  a_rotate_no_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == rtdw_pkg::PH_ROTATE |-> out_tdata[14:0] == 15'h0)
    else $error("rotating command carries forward speed");

  a_drive_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == rtdw_pkg::PH_DRIVE
    |-> out_tdata[14:0] >= rtdw_pkg::MIN_SPEED && out_tdata[30:15] == 16'h0)
    else $error("driving command out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

endmodule
